### design/fpmm_pkg.sv
package fpmm_pkg;

    // Matrix geometry
    localparam int MAX_DIM = 8;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;

    // Number formats
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = 52;
    localparam int PROD_W    = 2 * DATA_W;

    // Configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Stream payload layout
    localparam int IN_TDATA_W  = 40;
    localparam int IN_PAD_W    = IN_TDATA_W - (2 * IDX_W + DATA_W);
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (DATA_W + 2 * IDX_W);

    // Saturation limits
    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Operation codes carried in tuser
    typedef enum logic [1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A     = 2'd0,
        REG_INNER_SIZE = 2'd1,
        REG_COLS_B     = 2'd2
    } reg_idx_t;

    // Highest loop index for a dimension register: zero acts as one, large values as MAX_DIM.
    function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_W-1:0] d);
        logic [IDX_W-1:0] r;
        r = '0;
        if (d == '0)
        begin
            r = '0;
        end
        else if (d > CFG_W'(MAX_DIM))
        begin
            r = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            r = IDX_W'(d - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

### design/fixed_point_matrix_multiply.sv
// Fixed-point matrix multiply: holds matrix A (rows_a by inner_size) and matrix B
// (inner_size by cols_b) of signed Q16.16 elements in two 64-entry memories. An input
// transfer with tuser = 0 or 1 writes one element of A or B at (row, col); tuser = 3
// is dropped. A transfer with tuser = 2 streams out every element of C = A * B in
// row-major order, with tlast on the final one and tuser set where the element was
// clipped to the 32-bit range. Every product is shifted right by 16 and summed in a
// 52-bit accumulator. One shared 32x32 multiplier does all the work; each
// multiply-accumulate runs as a memory read, a multiply and an accumulate in turn.
// A compute waits while the output is held by m_tready, and no input is taken until
// it returns to idle. Elements read by a compute must have been loaded first; memory
// contents are not cleared by reset.
module fixed_point_matrix_multiply (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tdata: row_index[2:0], col_index[5:3], element_value[37:6], zero pad
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [fpmm_pkg::IN_TDATA_W-1:0]      s_tdata,
    // tuser: func[1:0]
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: product_value[31:0], out_row[34:32], out_col[37:35], zero pad
    output logic [fpmm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // tuser: saturated
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    input  logic                                 cfg_we,
    input  logic [fpmm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fpmm_pkg::CFG_W-1:0]           cfg_data
);
    import fpmm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_SAT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] rows_a_reg, inner_size_reg, cols_b_reg;

    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic [IDX_W-1:0] r_last_reg, r_last_next;
    logic [IDX_W-1:0] k_last_reg, k_last_next;
    logic [IDX_W-1:0] c_last_reg, c_last_next;

    logic [DATA_W-1:0]        mem_a [DEPTH];
    logic [DATA_W-1:0]        mem_b [DEPTH];
    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_shift;
    logic [ACC_W-1:0]         acc_reg, acc_next, acc_sum;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg;
    logic [IDX_W-1:0]  out_row_reg, out_col_reg;
    logic              out_sat_reg, out_last_reg;

    logic              s_xfer, load_a, load_b, start;
    logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
    logic [DATA_W-1:0] wdata;
    logic              out_free, out_load, last_elem;
    logic              sat_flag;
    logic [DATA_W-1:0] sat_value;

    // Input decode
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign waddr    = {s_tdata[IDX_W-1:0], s_tdata[2*IDX_W-1:IDX_W]};
    assign wdata    = s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];
    assign load_a   = s_xfer && (s_tuser == FUNC_LOAD_A);
    assign load_b   = s_xfer && (s_tuser == FUNC_LOAD_B);
    assign start    = s_xfer && (s_tuser == FUNC_COMPUTE);

    // Element addresses: A at (i, m), B at (m, j)
    assign a_raddr = {i_reg, m_reg};
    assign b_raddr = {m_reg, j_reg};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg     <= CFG_W'(MAX_DIM);
            inner_size_reg <= CFG_W'(MAX_DIM);
            cols_b_reg     <= CFG_W'(MAX_DIM);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS_A:     rows_a_reg     <= cfg_data;
                REG_INNER_SIZE: inner_size_reg <= cfg_data;
                REG_COLS_B:     cols_b_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Matrix memories with registered read data
    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            mem_a[waddr] <= wdata;
        end
        if (load_b)
        begin
            mem_b[waddr] <= wdata;
        end
        rd_a_reg <= mem_a[a_raddr];
        rd_b_reg <= mem_b[b_raddr];
    end

    // Shared multiplier, registered before the accumulate
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= rd_a_reg * rd_b_reg;
        end
    end

    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign acc_sum    = acc_reg + prod_shift[ACC_W-1:0];

    // Saturation of the accumulated sum to the data range
    always_comb
    begin
        sat_flag  = !((&acc_reg[ACC_W-1:DATA_W-1]) || !(|acc_reg[ACC_W-1:DATA_W-1]));
        sat_value = acc_reg[DATA_W-1:0];
        if (sat_flag)
        begin
            sat_value = acc_reg[ACC_W-1] ? DATA_MIN : DATA_MAX;
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = (state_reg == ST_SAT) && out_free;
    assign last_elem = (i_reg == r_last_reg) && (j_reg == c_last_reg);

    // Sequencer over output elements and inner products
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        m_next         = m_reg;
        r_last_next    = r_last_reg;
        k_last_next    = k_last_reg;
        c_last_next    = c_last_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    r_last_next = dim_last(rows_a_reg);
                    k_last_next = dim_last(inner_size_reg);
                    c_last_next = dim_last(cols_b_reg);
                    i_next      = '0;
                    j_next      = '0;
                    m_next      = '0;
                    acc_next    = '0;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next = acc_sum;
                if (m_reg == k_last_reg)
                begin
                    state_next = ST_SAT;
                end
                else
                begin
                    m_next     = m_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_SAT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    m_next         = '0;
                    acc_next       = '0;
                    if (last_elem)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                        if (j_reg == c_last_reg)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            m_reg         <= '0;
            r_last_reg    <= '0;
            k_last_reg    <= '0;
            c_last_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            m_reg         <= m_next;
            r_last_reg    <= r_last_next;
            k_last_reg    <= k_last_next;
            c_last_reg    <= c_last_next;
        end
    end

    // Accumulator and output payload
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (out_load)
        begin
            out_value_reg <= sat_value;
            out_row_reg   <= i_reg;
            out_col_reg   <= j_reg;
            out_sat_reg   <= sat_flag;
            out_last_reg  <= last_elem;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_col_reg, out_row_reg, out_value_reg};
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

    // A compute transfer starts at the first element and the first inner step.
    a_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == ST_READ && i_reg == '0 && j_reg == '0 && m_reg == '0))
        else $error("compute did not start at element zero");

    // Loop counters stay within the sizes captured at the start.
    a_counter_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |->
            (i_reg <= r_last_reg && j_reg <= c_last_reg && m_reg <= k_last_reg))
        else $error("loop counter beyond configured size");

    // Sending the final element returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_elem) |=> (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("final element did not end the compute");

    // A clipped element carries one of the two range limits.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (m_tdata[DATA_W-1:0] == DATA_MAX || m_tdata[DATA_W-1:0] == DATA_MIN))
        else $error("saturated element not at a range limit");

endmodule
